@@ hdl/gcsd_pkg.sv @@
// Package of the grid second-derivative stencil: shared constants, codes,
// coefficient table and the control word handed from the sequencer to the datapath.
// No dependencies.
package gcsd_pkg;

    localparam int MAX_DIM_DEF     = 64;
    localparam int HALF_WIDTH_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int OUT_W      = 20;
    localparam int POS_W_MAX  = 8;
    localparam int SLOT_W     = 4;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 19;

    localparam logic signed [COEF_W-1:0] NARROW_CENTER = -19'sd131072;
    localparam logic signed [COEF_W-1:0] NARROW_SIDE   = 19'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_I = 3'd0,
        CFG_SIZE_J = 3'd1,
        CFG_SIZE_K = 3'd2,
        CFG_AXIS   = 3'd3,
        CFG_WIDE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_I    = 2'd0,
        AXIS_J    = 2'd1,
        AXIS_K    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic                  valid;
        t_axis                 axis;
        logic                  wide;
        logic [SLOT_W-1:0]     slot;
        logic [POS_W_MAX-1:0]  pos_i;
        logic [POS_W_MAX-1:0]  pos_j;
        logic [POS_W_MAX-1:0]  pos_k;
        logic                  last;
    } t_item_ctl;

    // Q3.16 coefficients of the eighth-order stencil by tap distance.
    function automatic logic signed [COEF_W-1:0] wide_coef(input logic [2:0] tap_dist);
        logic signed [COEF_W-1:0] c;
        case (tap_dist)
            3'd0:    c = -19'sd186596;
            3'd1:    c = 19'sd104858;
            3'd2:    c = -19'sd13107;
            3'd3:    c = 19'sd1664;
            3'd4:    c = -19'sd117;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/gcsd_if.sv @@
// Channel interfaces of the grid second-derivative stencil: sample input,
// result output and configuration write. Depends on gcsd_pkg.
interface gcsd_in_if #(
    parameter int SAMPLE_BITS = gcsd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface gcsd_out_if #(
    parameter int POS_W = 6
);
    logic                                  valid;
    logic                                  ready;
    logic signed [gcsd_pkg::OUT_W-1:0]     deriv_value;
    logic [POS_W-1:0]                      pos_i;
    logic [POS_W-1:0]                      pos_j;
    logic [POS_W-1:0]                      pos_k;
    logic                                  frame_last;

    modport source (output valid, output deriv_value, output pos_i, output pos_j,
                    output pos_k, output frame_last, input ready);
    modport sink (input valid, input deriv_value, input pos_i, input pos_j,
                  input pos_k, input frame_last, output ready);
endinterface

interface gcsd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [gcsd_pkg::CFG_IDX_W-1:0]      index;
    logic [gcsd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/gcsd_lane_mem.sv @@
// Synchronous sample memory with one word of several lanes per address,
// lane-wise write and a registered whole-word read. No dependencies.
module gcsd_lane_mem #(
    parameter int DEPTH = 64,
    parameter int LANES = 9,
    parameter int WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(DEPTH)-1:0]             i_waddr,
    input  logic [$clog2(LANES)-1:0]             i_wlane,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [$clog2(DEPTH)-1:0]             i_raddr,
    output logic [LANES-1:0][WIDTH-1:0]          o_rdata
);

    logic [LANES-1:0][WIDTH-1:0] r_mem [DEPTH];
    logic [LANES-1:0][WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wlane] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gcsd_ctrl.sv @@
// Sequencer of the grid second-derivative stencil: configuration registers,
// raster counters, store addressing and the interior test. Depends on gcsd_pkg.
module gcsd_ctrl #(
    parameter int MAX_DIM    = gcsd_pkg::MAX_DIM_DEF,
    parameter int HALF_WIDTH = gcsd_pkg::HALF_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    gcsd_cfg_if.sink                                  i_cfg,
    input  logic                                      i_accept,
    output gcsd_pkg::t_item_ctl                       o_ctl,
    output logic [2*$clog2(MAX_DIM)-1:0]              o_plane_addr,
    output logic [$clog2(2*HALF_WIDTH+1)-1:0]         o_plane_lane,
    output logic [$clog2(MAX_DIM)-1:0]                o_row_addr,
    output logic [$clog2(2*HALF_WIDTH+1)-1:0]         o_row_lane
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int NW   = $clog2(MAX_DIM + 1);
    localparam int SW   = CW + 1;
    localparam int NTAP = 2 * HALF_WIDTH + 1;
    localparam int LW   = $clog2(NTAP);
    localparam int DW   = gcsd_pkg::CFG_DATA_W;
    localparam int CMPW = (NW > DW ? NW : DW) + 1;

    logic [NW-1:0]         r_size_i, r_size_j, r_size_k;
    gcsd_pkg::t_axis       r_axis;
    logic                  r_wide;
    logic [CW-1:0]         r_cnt_i, r_cnt_j, r_cnt_k;
    logic [LW-1:0]         r_jslot, r_kslot;
    logic [CW-1:0]         n_cnt_i, n_cnt_j, n_cnt_k;
    logic [LW-1:0]         n_jslot, n_kslot;
    logic                  cfg_we;

    function automatic logic [NW-1:0] clamp_size(input logic [DW-1:0] v);
        logic [CMPW-1:0] ve;
        logic [NW-1:0]   r;
        ve = CMPW'(v);
        if (ve < CMPW'(3)) begin
            r = NW'(3);
        end else if (ve > CMPW'(MAX_DIM)) begin
            r = NW'(MAX_DIM);
        end else begin
            r = NW'(ve);
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign cfg_we = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_i <= NW'(MAX_DIM);
            r_size_j <= NW'(MAX_DIM);
            r_size_k <= NW'(MAX_DIM);
            r_axis   <= gcsd_pkg::AXIS_I;
            r_wide   <= 1'b0;
        end else if (cfg_we) begin
            case (gcsd_pkg::t_cfg_idx'(i_cfg.index))
                gcsd_pkg::CFG_SIZE_I: r_size_i <= clamp_size(i_cfg.data);
                gcsd_pkg::CFG_SIZE_J: r_size_j <= clamp_size(i_cfg.data);
                gcsd_pkg::CFG_SIZE_K: r_size_k <= clamp_size(i_cfg.data);
                gcsd_pkg::CFG_AXIS:   r_axis <= gcsd_pkg::t_axis'(i_cfg.data[1:0]);
                gcsd_pkg::CFG_WIDE:   r_wide <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [SW-1:0] inext, jnext, knext;
        n_cnt_i = r_cnt_i;
        n_cnt_j = r_cnt_j;
        n_cnt_k = r_cnt_k;
        n_jslot = r_jslot;
        n_kslot = r_kslot;
        inext = SW'(r_cnt_i) + SW'(1);
        jnext = SW'(r_cnt_j) + SW'(1);
        knext = SW'(r_cnt_k) + SW'(1);
        if (inext >= SW'(r_size_i)) begin
            n_cnt_i = '0;
            if (jnext >= SW'(r_size_j)) begin
                n_cnt_j = '0;
                n_jslot = '0;
                if (knext >= SW'(r_size_k)) begin
                    n_cnt_k = '0;
                    n_kslot = '0;
                end else begin
                    n_cnt_k = CW'(knext);
                    n_kslot = (r_kslot == LW'(NTAP - 1)) ? '0 : r_kslot + LW'(1);
                end
            end else begin
                n_cnt_j = CW'(jnext);
                n_jslot = (r_jslot == LW'(NTAP - 1)) ? '0 : r_jslot + LW'(1);
            end
        end else begin
            n_cnt_i = CW'(inext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_i <= '0;
            r_cnt_j <= '0;
            r_cnt_k <= '0;
            r_jslot <= '0;
            r_kslot <= '0;
        end else if (i_accept) begin
            r_cnt_i <= n_cnt_i;
            r_cnt_j <= n_cnt_j;
            r_cnt_k <= n_cnt_k;
            r_jslot <= n_jslot;
            r_kslot <= n_kslot;
        end
    end

    assign o_plane_addr = {r_cnt_j, r_cnt_i};
    assign o_plane_lane = r_kslot;
    assign o_row_addr   = r_cnt_i;
    assign o_row_lane   = r_jslot;

    always_comb begin
        logic [SW-1:0] ci, cj, ck, ni, nj, nk, hh, h2;
        logic in_i, in_j, in_k, ax_i, ax_j, ax_k;
        logic lo_i, lo_j, lo_k, la_i, la_j, la_k;
        logic [SW-1:0] pi, pj, pk;
        ci = SW'(r_cnt_i);
        cj = SW'(r_cnt_j);
        ck = SW'(r_cnt_k);
        ni = SW'(r_size_i);
        nj = SW'(r_size_j);
        nk = SW'(r_size_k);
        hh = r_wide ? SW'(HALF_WIDTH) : SW'(1);
        h2 = hh + hh;
        in_i = (ci >= hh) && (ci + hh < ni);
        in_j = (cj >= hh) && (cj + hh < nj);
        in_k = (ck >= hh) && (ck + hh < nk);
        ax_i = (ci >= h2) && (ci < ni);
        ax_j = (cj >= h2) && (cj < nj);
        ax_k = (ck >= h2) && (ck < nk);
        lo_i = (ci + hh + SW'(1) == ni);
        lo_j = (cj + hh + SW'(1) == nj);
        lo_k = (ck + hh + SW'(1) == nk);
        la_i = (ci + SW'(1) == ni);
        la_j = (cj + SW'(1) == nj);
        la_k = (ck + SW'(1) == nk);
        pi = ci;
        pj = cj;
        pk = ck;
        o_ctl = '0;
        o_ctl.axis = r_axis;
        o_ctl.wide = r_wide;
        case (r_axis)
            gcsd_pkg::AXIS_I: begin
                o_ctl.valid = ax_i && in_j && in_k;
                o_ctl.last  = la_i && lo_j && lo_k;
                pi = ci - hh;
            end
            gcsd_pkg::AXIS_J: begin
                o_ctl.valid = in_i && ax_j && in_k;
                o_ctl.last  = lo_i && la_j && lo_k;
                o_ctl.slot  = gcsd_pkg::SLOT_W'(r_jslot);
                pj = cj - hh;
            end
            gcsd_pkg::AXIS_K: begin
                o_ctl.valid = in_i && in_j && ax_k;
                o_ctl.last  = lo_i && lo_j && la_k;
                o_ctl.slot  = gcsd_pkg::SLOT_W'(r_kslot);
                pk = ck - hh;
            end
            default: o_ctl.valid = 1'b0;
        endcase
        o_ctl.pos_i = gcsd_pkg::POS_W_MAX'(pi);
        o_ctl.pos_j = gcsd_pkg::POS_W_MAX'(pj);
        o_ctl.pos_k = gcsd_pkg::POS_W_MAX'(pk);
    end

`ifndef SYNTH
    a_jslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_jslot < LW'(NTAP)) && (r_kslot < LW'(NTAP)))
        else $error("plane or row slot out of range");
    a_jslot_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_j == '0) |-> (r_jslot == '0))
        else $error("row slot not aligned with row counter");
    a_kslot_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_k == '0) |-> (r_kslot == '0))
        else $error("plane slot not aligned with plane counter");
    a_no_axis_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.valid |-> (r_axis != gcsd_pkg::AXIS_NONE))
        else $error("result flagged with no axis selected");
`endif

endmodule

@@ hdl/gcsd_datapath.sv @@
// Datapath of the grid second-derivative stencil: recent-sample history, tap
// selection, coefficient products, sum, rounding, saturation and result register.
// Depends on gcsd_pkg and the channel interfaces.
module gcsd_datapath #(
    parameter int MAX_DIM     = gcsd_pkg::MAX_DIM_DEF,
    parameter int HALF_WIDTH  = gcsd_pkg::HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS = gcsd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    gcsd_in_if.sink                                            i_in,
    gcsd_out_if.source                                         o_out,
    input  gcsd_pkg::t_item_ctl                                i_ctl,
    input  logic [2*HALF_WIDTH:0][SAMPLE_BITS-1:0]             i_plane_word,
    input  logic [2*HALF_WIDTH:0][SAMPLE_BITS-1:0]             i_row_word
);

    localparam int NTAP  = 2 * HALF_WIDTH + 1;
    localparam int LW    = $clog2(NTAP);
    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = $clog2(MAX_DIM);
    localparam int OPW   = SB + 1;
    localparam int PRD_W = OPW + gcsd_pkg::COEF_W;
    localparam int ACC_W = PRD_W + 3;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2**(gcsd_pkg::OUT_W-1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(2**(gcsd_pkg::FRAC_BITS-1));

    logic accept, adv1, adv2, adv_o;

    logic signed [SB-1:0]   r_hist [NTAP-1];
    logic                   r_v1;
    gcsd_pkg::t_item_ctl    r1_ctl;
    logic signed [SB-1:0]   r1_sample;
    logic signed [SB-1:0]   r1_hist [NTAP-1];

    logic signed [SB-1:0]   back [NTAP];
    logic signed [PRD_W-1:0] prod [HALF_WIDTH+1];

    logic                   r_v2;
    gcsd_pkg::t_item_ctl    r2_ctl;
    logic signed [PRD_W-1:0] r2_prod [HALF_WIDTH+1];

    logic signed [ACC_W-1:0] acc_sum, rnd;
    logic signed [gcsd_pkg::OUT_W-1:0] sat;

    logic                   r_o_valid;
    logic signed [gcsd_pkg::OUT_W-1:0] r_o_value;
    logic [PW-1:0]          r_o_pi, r_o_pj, r_o_pk;
    logic                   r_o_last;

    assign adv_o = !r_o_valid || o_out.ready;
    assign adv2  = !r_v2 || adv_o;
    assign adv1  = !r_v1 || adv2;
    assign i_in.ready = adv1;
    assign accept = i_in.valid && adv1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist[0] <= i_in.sample;
            for (int m = 1; m < NTAP - 1; m++) begin
                r_hist[m] <= r_hist[m-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= accept && i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_ctl    <= i_ctl;
            r1_sample <= i_in.sample;
            for (int m = 0; m < NTAP - 1; m++) begin
                r1_hist[m] <= r_hist[m];
            end
        end
    end

    always_comb begin
        logic [LW:0] idx;
        logic [LW:0] slot;
        slot = (LW + 1)'(r1_ctl.slot);
        back[0] = r1_sample;
        for (int b = 1; b < NTAP; b++) begin
            if (slot >= (LW + 1)'(b)) begin
                idx = slot - (LW + 1)'(b);
            end else begin
                idx = slot + (LW + 1)'(NTAP - b);
            end
            case (r1_ctl.axis)
                gcsd_pkg::AXIS_J: back[b] = i_row_word[LW'(idx)];
                gcsd_pkg::AXIS_K: back[b] = i_plane_word[LW'(idx)];
                default:          back[b] = r1_hist[b-1];
            endcase
        end
    end

    always_comb begin
        logic signed [OPW-1:0]                opd;
        logic signed [gcsd_pkg::COEF_W-1:0]   cf;
        for (int d = 0; d <= HALF_WIDTH; d++) begin
            if (d == 0) begin
                opd = r1_ctl.wide ? OPW'(back[HALF_WIDTH]) : OPW'(back[1]);
                cf  = r1_ctl.wide ? gcsd_pkg::wide_coef(3'(d)) : gcsd_pkg::NARROW_CENTER;
            end else if (d == 1) begin
                opd = r1_ctl.wide
                    ? OPW'(back[HALF_WIDTH-1]) + OPW'(back[HALF_WIDTH+1])
                    : OPW'(back[0]) + OPW'(back[2]);
                cf  = r1_ctl.wide ? gcsd_pkg::wide_coef(3'(d)) : gcsd_pkg::NARROW_SIDE;
            end else begin
                opd = r1_ctl.wide
                    ? OPW'(back[HALF_WIDTH-d]) + OPW'(back[HALF_WIDTH+d])
                    : '0;
                cf  = gcsd_pkg::wide_coef(3'(d));
            end
            prod[d] = PRD_W'(opd) * PRD_W'(cf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_ctl <= r1_ctl;
            for (int d = 0; d <= HALF_WIDTH; d++) begin
                r2_prod[d] <= prod[d];
            end
        end
    end

    always_comb begin
        acc_sum = '0;
        for (int d = 0; d <= HALF_WIDTH; d++) begin
            acc_sum = acc_sum + ACC_W'(r2_prod[d]);
        end
        rnd = (acc_sum + HALF_LSB) >>> gcsd_pkg::FRAC_BITS;
        if (rnd > SAT_HI) begin
            sat = gcsd_pkg::OUT_W'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            sat = gcsd_pkg::OUT_W'(SAT_LO);
        end else begin
            sat = gcsd_pkg::OUT_W'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_o) begin
            r_o_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_o_value <= sat;
            r_o_pi    <= PW'(r2_ctl.pos_i);
            r_o_pj    <= PW'(r2_ctl.pos_j);
            r_o_pk    <= PW'(r2_ctl.pos_k);
            r_o_last  <= r2_ctl.last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.deriv_value = r_o_value;
    assign o_out.pos_i       = r_o_pi;
    assign o_out.pos_j       = r_o_pj;
    assign o_out.pos_k       = r_o_pk;
    assign o_out.frame_last  = r_o_last;

endmodule

@@ hdl/grid_central_second_derivative_top.sv @@
// Top level of the grid second-derivative stencil: sequencer, two sample
// memories and the arithmetic datapath. Depends on gcsd_pkg, the channel
// interfaces, gcsd_lane_mem, gcsd_ctrl and gcsd_datapath.
//
// Samples of a 3D grid enter in raster order (i fastest), one item per cycle
// unless the output holds off, with no gaps of its own; each interior point
// along the chosen axis yields one result, which passes in turn through the
// stage-one, product and output registers. The plane memory keeps the last
// 2*HALF_WIDTH+1 planes per (i, j) column and serves the k axis, the row
// memory keeps the last rows per i and serves the j axis, and a short sample
// history serves the i axis; each point's other taps are all registered,
// so throughput stays at one item per clock unless the output holds off.
// The memories need no clearing after reset. The output is registered and
// back-pressure propagates through the two-stage arithmetic pipeline.
module grid_central_second_derivative_top #(
    parameter int MAX_DIM     = gcsd_pkg::MAX_DIM_DEF,
    parameter int HALF_WIDTH  = gcsd_pkg::HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS = gcsd_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcsd_in_if.sink     i_in,
    gcsd_out_if.source  o_out,
    gcsd_cfg_if.sink    i_cfg
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int NTAP = 2 * HALF_WIDTH + 1;
    localparam int LW   = $clog2(NTAP);

    gcsd_pkg::t_item_ctl                 item_ctl;
    logic [2*CW-1:0]                     plane_addr;
    logic [LW-1:0]                       plane_lane;
    logic [CW-1:0]                       row_addr;
    logic [LW-1:0]                       row_lane;
    logic [NTAP-1:0][SAMPLE_BITS-1:0]    plane_word;
    logic [NTAP-1:0][SAMPLE_BITS-1:0]    row_word;
    logic                                accept;

    assign accept = i_in.valid && i_in.ready;

    gcsd_ctrl #(
        .MAX_DIM    (MAX_DIM),
        .HALF_WIDTH (HALF_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_accept     (accept),
        .o_ctl        (item_ctl),
        .o_plane_addr (plane_addr),
        .o_plane_lane (plane_lane),
        .o_row_addr   (row_addr),
        .o_row_lane   (row_lane)
    );

    gcsd_lane_mem #(
        .DEPTH (MAX_DIM * MAX_DIM),
        .LANES (NTAP),
        .WIDTH (SAMPLE_BITS)
    ) u_plane_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (plane_addr),
        .i_wlane (plane_lane),
        .i_wdata (i_in.sample),
        .i_re    (accept),
        .i_raddr (plane_addr),
        .o_rdata (plane_word)
    );

    gcsd_lane_mem #(
        .DEPTH (MAX_DIM),
        .LANES (NTAP),
        .WIDTH (SAMPLE_BITS)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (row_addr),
        .i_wlane (row_lane),
        .i_wdata (i_in.sample),
        .i_re    (accept),
        .i_raddr (row_addr),
        .o_rdata (row_word)
    );

    gcsd_datapath #(
        .MAX_DIM     (MAX_DIM),
        .HALF_WIDTH  (HALF_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_ctl        (item_ctl),
        .i_plane_word (plane_word),
        .i_row_word   (row_word)
    );

endmodule
